/* rtl/lowest_free_gate_allocator_unit_defines.svh */
// Assertion macros for the checker file of the gate allocator.
`ifndef LOWEST_FREE_GATE_ALLOCATOR_UNIT_DEFINES_SVH
`define LOWEST_FREE_GATE_ALLOCATOR_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFGA_ASSERT_SAME(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfga: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LFGA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfga: next-cycle check failed");

`endif

/* rtl/lfga_pkg.sv */
package lfga_pkg;

	// Reset value of the gate limit register.
	localparam logic [6:0] LIMIT_RESET = 7'd64;

	// Largest served count; the count saturates here.
	localparam logic [31:0] SERVED_MAX = 32'hFFFF_FFFF;

	// One input interval.
	typedef struct packed {
		logic [31:0] interval_start;
		logic [31:0] interval_end;
		logic        first_of_set;
	} in_item_t;

	// One allocation result.
	typedef struct packed {
		logic [5:0]  gate_number;
		logic [31:0] served_count;
		logic        rejected;
	} out_item_t;

	// One word of the gate memory.
	typedef struct packed {
		logic        used;
		logic [31:0] served;
		logic [31:0] end_time;
	} gate_entry_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN,
		ST_WRITE
	} state_t;

endpackage

/* rtl/lowest_free_gate_allocator_unit.sv */
// Lowest-free gate allocator.
// Input channel in_valid/in_ready/in_item carries one interval per transaction;
// the sender must keep starts in nondecreasing order; the block does not enforce it.
// Output channel out_valid/out_ready/out_item returns one result per interval:
// the lowest free gate and its served count, or the rejected flag when no gate
// below the limit is free. Configuration channel cfg_valid/cfg_ready/cfg_data
// writes the gate limit; cfg_ready is always high and the limit resets to 64.
// Each item scans the gate memory one entry per cycle through its single read
// port; the memory returns each entry registered, it is then tested, and the
// first free gate, or a rejection at the effective limit, goes through the
// write-back state to the output register. With a limit of zero the item is
// rejected without a read. An item with first_of_set first clears the memory.
// The next item is taken in the cycle after a result is handed over to the
// output register, so no new item is taken while one is in the controller.
// After reset the block runs a clearing pass over all NUM_GATES entries with
// in_ready low; configuration writes are taken during it.
// A finished result waits in the output register while the receiver stalls;
// the next item is accepted and scanned meanwhile, and holds before its write
// back until the output register is free.
module lowest_free_gate_allocator_unit #(
	parameter int NUM_GATES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lfga_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lfga_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [6:0]          cfg_data
);

	import lfga_pkg::*;

	localparam int AW = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;

	logic [6:0]  limit_q;
	logic        out_valid_q;
	out_item_t   out_item_q;
	logic        res_valid;
	logic        res_take;
	out_item_t   res_item;
	logic        mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	gate_entry_t mem_rd_data;
	logic        mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	gate_entry_t mem_wr_data;
	logic [$bits(gate_entry_t)-1:0] rd_bits;

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// Output register: the controller hands over a result when it is free.
	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_item_q <= res_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Scan and write-back controller.
	lfga_ctrl #(
		.NUM_GATES(NUM_GATES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.gate_limit (limit_q),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res_item   (res_item),
		.mem_rd_en  (mem_rd_en),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data)
	);

	// Gate memory: used flag, served count and end time per gate.
	lfga_ram #(
		.WIDTH($bits(gate_entry_t)),
		.DEPTH(NUM_GATES)
	) u_ram (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(rd_bits)
	);

	assign mem_rd_data = gate_entry_t'(rd_bits);

endmodule

/* rtl/lfga_ram.sv */
module lfga_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port: data appears in the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/lfga_ctrl.sv */
module lfga_ctrl #(
	parameter int NUM_GATES = 64,
	localparam int AW = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lfga_pkg::in_item_t    in_item,
	input  logic [6:0]            gate_limit,
	output logic                  res_valid,
	input  logic                  res_take,
	output lfga_pkg::out_item_t   res_item,
	output logic                  mem_rd_en,
	output logic [AW-1:0]         mem_rd_addr,
	input  lfga_pkg::gate_entry_t mem_rd_data,
	output logic                  mem_wr_en,
	output logic [AW-1:0]         mem_wr_addr,
	output lfga_pkg::gate_entry_t mem_wr_data
);

	import lfga_pkg::*;

	localparam int CW = $clog2(NUM_GATES + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          rd_valid_s1, rd_valid_d;
	logic [AW-1:0] rd_idx_s1;
	logic [31:0]   start_q;
	logic [31:0]   end_q;
	logic [AW-1:0] pick_q, pick_d;
	logic [31:0]   served_q, served_d;
	logic          rejected_q, rejected_d;
	logic [CW-1:0] limit_eff;
	logic          entry_free;
	logic [31:0]   served_inc;
	logic [AW+5:0] pick_wide;
	logic          sweep_last;

	// A limit beyond the number of gates acts as the number of gates.
	always_comb begin
		if (32'(gate_limit) > 32'(NUM_GATES)) begin
			limit_eff = CW'(NUM_GATES);
		end else begin
			limit_eff = CW'(gate_limit);
		end
	end

	// Test of the entry returned by the memory, and its saturating count.
	assign entry_free = !mem_rd_data.used || (mem_rd_data.end_time < start_q);
	assign served_inc = (mem_rd_data.served == SERVED_MAX) ? SERVED_MAX
		: mem_rd_data.served + 32'd1;
	assign sweep_last = (cnt_q == CW'(NUM_GATES - 1));

	// Next state, memory access and handshake outputs.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		rd_valid_d  = 1'b0;
		pick_d      = pick_q;
		served_d    = served_q;
		rejected_d  = rejected_q;
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		mem_rd_en   = 1'b0;
		mem_rd_addr = cnt_q[AW-1:0];
		mem_wr_en   = 1'b0;
		mem_wr_addr = cnt_q[AW-1:0];
		mem_wr_data = '0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				// Clearing pass: one entry per cycle.
				mem_wr_en = 1'b1;
				if (sweep_last) begin
					cnt_d   = '0;
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_SCAN;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cnt_d   = '0;
					state_d = in_item.first_of_set ? ST_CLEAR : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_valid_s1 && entry_free) begin
					pick_d     = rd_idx_s1;
					served_d   = served_inc;
					rejected_d = 1'b0;
					state_d    = ST_WRITE;
				end else if (cnt_q == limit_eff) begin
					if (!rd_valid_s1) begin
						rejected_d = 1'b1;
						state_d    = ST_WRITE;
					end
				end else begin
					mem_rd_en  = 1'b1;
					rd_valid_d = 1'b1;
					cnt_d      = cnt_q + CW'(1);
				end
			end
			ST_WRITE: begin
				// Write back the chosen gate as the result leaves.
				res_valid   = 1'b1;
				mem_wr_addr = pick_q;
				mem_wr_data = '{used: 1'b1, served: served_q, end_time: end_q};
				if (res_take) begin
					mem_wr_en = !rejected_q;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rejected_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			rd_valid_s1 <= rd_valid_d;
			rejected_q  <= rejected_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[AW-1:0];
		pick_q    <= pick_d;
		served_q  <= served_d;
		if (in_valid && in_ready) begin
			start_q <= in_item.interval_start;
			end_q   <= in_item.interval_end;
		end
	end

	// The gate number is the index masked to six bits.
	assign pick_wide = {6'd0, pick_q};

	always_comb begin
		res_item.rejected = rejected_q;
		if (rejected_q) begin
			res_item.gate_number  = '0;
			res_item.served_count = '0;
		end else begin
			res_item.gate_number  = pick_wide[5:0];
			res_item.served_count = served_q;
		end
	end

endmodule

/* rtl/lfga_checker.sv */
`include "lowest_free_gate_allocator_unit_defines.svh"

module lfga_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input lfga_pkg::out_item_t out_item
);

	import lfga_pkg::*;

	// A stalled result keeps its contents.
	`LFGA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

	// A rejection carries neither a gate number nor a count.
	`LFGA_ASSERT_SAME(a_reject_zero, out_valid && out_item.rejected,
		out_item.gate_number == 6'd0 && out_item.served_count == 32'd0)

	// A granted gate has served at least this interval.
	`LFGA_ASSERT_SAME(a_grant_count, out_valid && !out_item.rejected,
		out_item.served_count != 32'd0)

	// Items are handled one at a time: no acceptance in the cycle after one.
	`LFGA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind lowest_free_gate_allocator_unit lfga_checker u_lfga_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);

/* verif/tb_top.sv */
module tb_top;

	import lfga_pkg::*;

	localparam int          GATES        = 64;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned PHASE_ITEMS  = 100;
	localparam int unsigned END_SETTLE   = 2 * GATES + 8;
	localparam int unsigned PHASE_SETTLE = 4;

	// Receiver behaviour; a new mode is drawn when the current one runs out.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	// Mirror of the gate memory; predicts each allocation and checks the results.
	class allocation_board #(parameter int NGATES = 64);
		logic [31:0] end_time [NGATES];
		logic        used [NGATES];
		logic [31:0] served [NGATES];
		logic [6:0]  limit;
		out_item_t   pending_allocations [$];
		int unsigned mismatches;

		function new();
			foreach (used[g]) begin
				end_time[g] = '0;
				used[g] = 1'b0;
				served[g] = '0;
			end
			limit = LIMIT_RESET;
			mismatches = 0;
		endfunction

		function void set_limit(logic [6:0] value);
			limit = value;
		endfunction

		function int outstanding();
			return pending_allocations.size();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// Works out the gate that an accepted interval receives.
		function void note_interval(in_item_t item);
			out_item_t res;
			int        usable;
			int        pick;
			int        g;
			bit        found;
			if (item.first_of_set) begin
				foreach (used[i]) begin
					used[i] = 1'b0;
					served[i] = '0;
				end
			end
			usable = (int'(limit) > NGATES) ? NGATES : int'(limit);
			found = 1'b0;
			pick = 0;
			for (g = 0; g < usable && !found; g++) begin
				if (!used[g] || end_time[g] < item.interval_start) begin
					pick = g;
					found = 1'b1;
				end
			end
			res = '0;
			if (!found) begin
				res.rejected = 1'b1;
			end else begin
				used[pick] = 1'b1;
				end_time[pick] = item.interval_end;
				if (served[pick] != SERVED_MAX) begin
					served[pick] = served[pick] + 1;
				end
				res.gate_number = 6'(pick);
				res.served_count = served[pick];
			end
			pending_allocations.push_back(res);
		endfunction

		// Compares a delivered result with the oldest prediction.
		function void check_allocation(out_item_t got);
			out_item_t want;
			if (pending_allocations.size() == 0) begin
				report($sformatf("unexpected result: gate %0d count %0d rejected %0b",
					got.gate_number, got.served_count, got.rejected));
				return;
			end
			want = pending_allocations.pop_front();
			if (got.gate_number !== want.gate_number || got.served_count !== want.served_count
					|| got.rejected !== want.rejected) begin
				report($sformatf({"allocation mismatch: expected gate %0d count %0d rejected %0b,",
					" got gate %0d count %0d rejected %0b"},
					want.gate_number, want.served_count, want.rejected,
					got.gate_number, got.served_count, got.rejected));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;

	allocation_board #(GATES) board;
	int unsigned cycle_count = 0;
	int unsigned burst_left = 0;
	logic [31:0] cur_start = '0;
	int unsigned step_max = 0;
	int unsigned dur_max = 0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int unsigned rx_mode_left = 0;

	lowest_free_gate_allocator_unit #(
		.NUM_GATES(GATES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// Free-running clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watch the input and output channels and feed every transaction to the scoreboard.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.note_interval(in_item);
			end
			if (out_valid && out_ready) begin
				board.check_allocation(out_item);
			end
		end
	end

	// Receiver stalls follow a pattern that changes mode from time to time.
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(50, 400);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		case (rx_mode)
			RX_ALWAYS: begin
				out_ready <= 1'b1;
			end
			RX_COIN: begin
				out_ready <= ($urandom_range(0, 1) == 1);
			end
			RX_PERIODIC: begin
				out_ready <= ((cycle_count % 7) < 2);
			end
			default: begin
				out_ready <= ($urandom_range(0, 15) == 0);
			end
		endcase
	end

	function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic in_item_t interval(logic [31:0] s, logic [31:0] e, logic first);
		in_item_t item;
		item.interval_start = s;
		item.interval_end = e;
		item.first_of_set = first;
		return item;
	endfunction

	// Mostly well-ordered sets of intervals, with a little noise mixed in.
	function automatic in_item_t next_interval(bit new_set);
		int unsigned roll;
		in_item_t    item;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			return interval($urandom, $urandom, 1'($urandom_range(0, 1)));
		end
		item.first_of_set = 1'b0;
		if (new_set || roll < 8) begin
			if ($urandom_range(0, 3) == 0) begin
				cur_start = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			end else begin
				cur_start = $urandom;
			end
			item.first_of_set = 1'b1;
		end else begin
			cur_start = sat_add(cur_start, $urandom_range(0, step_max));
		end
		item.interval_start = cur_start;
		if (roll < 11) begin
			item.interval_end = $urandom;
		end else begin
			item.interval_end = sat_add(cur_start, $urandom_range(0, dur_max));
		end
		return item;
	endfunction

	// Offer one interval, in bursts separated by random gaps.
	task automatic send_item(in_item_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_limit(logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_limit(value);
	endtask

	// Stop sending and wait until every predicted result has been delivered.
	task automatic drain(int unsigned settle);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Hand-picked intervals: empty and busy gates, extremes, clears and odd limits.
	task automatic run_directed();
		send_item(interval(32'd0, 32'd0, 1'b1));
		send_item(interval(32'd0, 32'd5, 1'b0));
		send_item(interval(32'd1, 32'hFFFF_FFFF, 1'b0));
		send_item(interval(32'd6, 32'd10, 1'b0));
		send_item(interval(32'd6, 32'd6, 1'b0));
		// A start that goes backwards is still handled by the same lowest-free scan.
		send_item(interval(32'd5, 32'd7, 1'b0));
		send_item(interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		send_item(interval(32'hFFFF_FFFF, 32'd0, 1'b0));
		send_item(interval(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0));
		drain(PHASE_SETTLE);
		// A single gate: busy gives a rejection, a clear frees it again.
		write_limit(7'd1);
		send_item(interval(32'd10, 32'd20, 1'b1));
		send_item(interval(32'd15, 32'd30, 1'b0));
		send_item(interval(32'd21, 32'd21, 1'b0));
		send_item(interval(32'd21, 32'd40, 1'b1));
		drain(PHASE_SETTLE);
		// No gate at all.
		write_limit(7'd0);
		send_item(interval(32'd100, 32'd200, 1'b1));
		send_item(interval(32'd300, 32'd300, 1'b0));
		drain(PHASE_SETTLE);
		// A limit above the gate count behaves as the full set.
		write_limit(7'd127);
		send_item(interval(32'hAAAA_AAAA, 32'h5555_5555, 1'b1));
		send_item(interval(32'h5555_5555, 32'hAAAA_AAAA, 1'b0));
		drain(PHASE_SETTLE);
		write_limit(7'd2);
		send_item(interval(32'd0, 32'hFFFF_FFFF, 1'b1));
		send_item(interval(32'd0, 32'hFFFF_FFFF, 1'b0));
		send_item(interval(32'd1, 32'd2, 1'b0));
		drain(PHASE_SETTLE);
	endtask

	task automatic run_random_phase(logic [6:0] value);
		case ($urandom_range(0, 2))
			0: step_max = 0;
			1: step_max = 3;
			default: step_max = 40;
		endcase
		case ($urandom_range(0, 2))
			0: dur_max = 0;
			1: dur_max = 25;
			default: dur_max = 2000;
		endcase
		write_limit(value);
		for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
			send_item(next_interval(i == 0));
		end
		drain(PHASE_SETTLE);
	endtask

	// Main sequence.
	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random_phase(7'd1);
		run_random_phase(7'd4);
		run_random_phase(7'd0);
		run_random_phase(7'd127);
		run_random_phase(7'd64);
		run_random_phase(7'd2);
		run_random_phase(7'd65);
		run_random_phase(7'd16);
		run_random_phase(7'd33);
		run_random_phase(7'd8);
		run_random_phase(7'($urandom_range(0, 127)));
		run_random_phase(7'($urandom_range(1, 64)));
		drain(END_SETTLE);
		if (board.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/lfga_pkg.sv
rtl/lfga_ram.sv
rtl/lfga_ctrl.sv
rtl/lowest_free_gate_allocator_unit.sv
rtl/lfga_checker.sv
verif/tb_top.sv
